### hw/rtl/mie_pkg.sv
// Package for the modular inverse block: default width, sequencer states, digit bundle.
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

  localparam int VALUE_BITS_DEF = 31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_UPDATE,
    S_FIX,
    S_WRAP,
    S_OUT
  } mie_state_t;

  // One quotient digit handed from the divider to the coefficient unit
  typedef struct packed {
    logic valid;
    logic q;
  } digit_t;

endpackage

`default_nettype wire

### hw/rtl/modular_inverse_ext_euclid.sv
// Top level: modular inverse by the extended Euclidean algorithm.
//
// Requests carry value_a and value_b on req_valid / req_stall; a request is
// taken at a clock edge with req_valid high and req_stall low. Results leave
// on res_valid / res_stall with inverse, coprime and zero_operand.
// The larger operand L and smaller S are ordered on entry; the block then
// runs Euclid steps on (L, S), tracking the coefficient of S.
// Each Euclid step is paced by the radix-2 divider, which produces one quotient
// digit per cycle. A zero operand skips the Euclid steps and goes straight
// from S_IDLE to S_OUT, the state that loads the output register.
// One item is worked on at a time; req_stall is high while an item runs.
// A new request is taken while a finished result still waits in the output
// register; if res_stall holds that result, the next item waits at its end.
// Synchronous reset drops any item in flight and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module modular_inverse_ext_euclid
  import mie_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire logic [VALUE_BITS-1:0] value_a,
  input  wire logic [VALUE_BITS-1:0] value_b,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output logic [VALUE_BITS-1:0]      inverse,
  output logic                       coprime,
  output logic                       zero_operand
);

  localparam int W = VALUE_BITS;

  mie_state_t state, state_next;

  logic [W-1:0] big;
  logic [W-1:0] rp;
  logic [W-1:0] rc;
  logic [W:0]   cp;
  logic [W:0]   cc;
  logic [W:0]   res;
  logic         cop;
  logic         zflag;

  logic [W-1:0] in_big;
  logic [W-1:0] in_small;
  logic         accept;
  logic         div_start;
  logic         out_load;

  digit_t       digit;
  logic         div_done;
  logic [W-1:0] div_rem;
  logic [W:0]   coef_next;

  // Order the operands
  always_comb begin
    in_big   = (value_a > value_b) ? value_a : value_b;
    in_small = (value_a < value_b) ? value_a : value_b;
  end

  mie_div #(.VALUE_BITS(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rp),
    .divisor   (rc),
    .digit     (digit),
    .done      (div_done),
    .remainder (div_rem)
  );

  mie_coef #(.VALUE_BITS(W)) u_coef (
    .clk       (clk),
    .clear     (div_start),
    .digit     (digit),
    .coef_cur  (cc),
    .coef_prev (cp),
    .coef_next (coef_next)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (in_small == '0) ? S_OUT : S_START;
        end
      end
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: state_next = (div_rem == '0) ? S_FIX : S_START;
      S_FIX:    state_next = S_WRAP;
      S_WRAP:   state_next = S_OUT;
      S_OUT: begin
        if (!res_valid || !res_stall) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_stall = (state != S_IDLE);
    accept    = (state == S_IDLE) && req_valid;
    div_start = (state == S_START);
    out_load  = (state == S_OUT) && (!res_valid || !res_stall);
  end

  // Hold state and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Euclid datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          big   <= in_big;
          rp    <= in_big;
          rc    <= in_small;
          cp    <= '0;
          cc    <= (W+1)'(1);
          res   <= '0;
          cop   <= 1'b0;
          zflag <= (in_small == '0);
        end
      end
      S_UPDATE: begin
        if (div_rem != '0) begin
          rp <= rc;
          rc <= div_rem;
          cp <= cc;
          cc <= coef_next;
        end
      end
      S_FIX: begin
        cop <= (rc == W'(1));
        res <= cc[W] ? (cc + {1'b0, big}) : cc;
      end
      S_WRAP: begin
        // Only a modulus of one reaches this subtract
        if (res >= {1'b0, big}) begin
          res <= res - {1'b0, big};
        end
      end
      default: begin
      end
    endcase
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      inverse      <= cop ? res[W-1:0] : '0;
      coprime      <= cop;
      zero_operand <= zflag;
    end
  end

  // Divider completes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider completion outside the divide state");

  // The flags exclude each other, and a nonzero inverse implies coprime
  a_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!(coprime && zero_operand) && ((inverse == '0) || coprime)))
    else $error("inconsistent result flags");

  // A delivered inverse lies below the larger operand of its item
  a_inverse_range: assert property (@(posedge clk) disable iff (rst)
    out_load && cop |-> (res < {1'b0, big}))
    else $error("inverse out of range");

endmodule

`default_nettype wire

### hw/rtl/mie_div.sv
// Radix-2 restoring divider that emits one quotient digit per cycle, MSB first.
`timescale 1ns / 1ps
`default_nettype none

module mie_div
  import mie_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output digit_t                     digit,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      remainder
);

  localparam int W    = VALUE_BITS;
  localparam int CNTW = $clog2(W + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [W-1:0]    dsr;
  logic [W-1:0]    shf;
  logic [W-1:0]    part;

  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            ge;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    trial = {part, shf[W-1]};
    diff  = trial - {1'b0, dsr};
    ge    = (trial >= {1'b0, dsr});
  end

  // Control: run for one digit per bit of the dividend
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(W);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: shift the dividend out, keep the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dsr  <= divisor;
      shf  <= dividend;
      part <= '0;
    end else if (busy) begin
      shf  <= {shf[W-2:0], 1'b0};
      part <= ge ? diff[W-1:0] : trial[W-1:0];
    end
  end

  assign digit.valid = busy;
  assign digit.q     = ge;
  assign remainder   = part;

  // The sequencer never divides by zero
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> (dsr != '0))
    else $error("divider running with a zero divisor");

  // The remainder is reduced when the division completes
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (part < dsr))
    else $error("remainder not below divisor at completion");

endmodule

`default_nettype wire

### hw/rtl/mie_coef.sv
// Coefficient unit: accumulates coef * quotient digit by digit, then forms the next coefficient.
`timescale 1ns / 1ps
`default_nettype none

module mie_coef
  import mie_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                clear,
  input  wire digit_t              digit,
  input  wire logic [VALUE_BITS:0] coef_cur,
  input  wire logic [VALUE_BITS:0] coef_prev,
  output logic [VALUE_BITS:0]      coef_next
);

  localparam int W = VALUE_BITS;

  // Product kept modulo 2^(W+1); the true next coefficient fits that range
  logic [W:0] prod;

  // Horner step: double and add the current coefficient on a one digit
  always_ff @(posedge clk) begin
    if (clear) begin
      prod <= '0;
    end else if (digit.valid) begin
      prod <= {prod[W-1:0], 1'b0} + (digit.q ? coef_cur : '0);
    end
  end

  assign coef_next = coef_prev - prod;

endmodule

`default_nettype wire
